// ===== src/esq_pkg.sv =====
package esq_pkg;

   localparam int SAMPLE_W = 12;
   localparam int READING_W = 20;
   localparam int WINDOW_W = 24;
   localparam int FALLBACK_W = 18;
   localparam int SHORT_FALLBACK_W = 12;
   localparam int NUM_SENSORS = 4;
   localparam int CSR_INDEX_W = 3;

   localparam logic [1:0] SENSOR_AIR_FLOW = 2'd0;
   localparam logic [1:0] SENSOR_AIR_TEMP = 2'd1;
   localparam logic [1:0] SENSOR_WATER_TEMP = 2'd2;
   localparam logic [1:0] SENSOR_THROTTLE = 2'd3;

   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_HIGH = 2'd1;
   localparam logic [1:0] FAULT_LOW = 2'd2;

   localparam logic [1:0] TRIGGER_NONE = 2'd0;
   localparam logic [1:0] TRIGGER_CONV0 = 2'd1;
   localparam logic [1:0] TRIGGER_CONV1 = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_AIR_FLOW_WINDOW = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_AIR_TEMP_WINDOW = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WATER_TEMP_WINDOW = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_THROTTLE_WINDOW = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AIR_FLOW_FALLBACK = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_AIR_TEMP_FALLBACK = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WATER_TEMP_FALLBACK = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_THROTTLE_FALLBACK = 3'd7;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'hFFF000;

   localparam logic [SAMPLE_W-1:0] WATER_BREAK_0 = 12'd488;
   localparam logic [SAMPLE_W-1:0] WATER_BREAK_1 = 12'd566;
   localparam logic [SAMPLE_W-1:0] WATER_BREAK_2 = 12'd836;
   localparam logic [SAMPLE_W-1:0] WATER_BREAK_3 = 12'd1309;

   localparam logic [18:0] WATER_OFFSET_0 = 19'd277930;
   localparam logic [18:0] WATER_OFFSET_1 = 19'd400769;
   localparam logic [18:0] WATER_OFFSET_2 = 19'd215333;
   localparam logic [18:0] WATER_OFFSET_3 = 19'd167552;
   localparam logic [18:0] WATER_OFFSET_4 = 19'd126934;

   localparam logic [8:0] WATER_SLOPE_0 = 9'd209;
   localparam logic [8:0] WATER_SLOPE_1 = 9'd462;
   localparam logic [8:0] WATER_SLOPE_2 = 9'd133;
   localparam logic [8:0] WATER_SLOPE_3 = 9'd76;
   localparam logic [8:0] WATER_SLOPE_4 = 9'd45;

   typedef struct packed {
      logic                converter;
      logic [SAMPLE_W-1:0] sample;
      logic                running;
   } req_type;

   typedef struct packed {
      logic [1:0]                  sensor;
      logic signed [READING_W-1:0] reading;
      logic [1:0]                  fault;
      logic [1:0]                  next_channel;
      logic [1:0]                  trigger;
   } rsp_type;

   typedef struct packed {
      logic [NUM_SENSORS-1:0][WINDOW_W-1:0]   window;
      logic [NUM_SENSORS-1:0][FALLBACK_W-1:0] fallback;
   } cfg_type;

   typedef struct packed {
      logic [1:0] sensor;
      logic [1:0] next_channel;
      logic [1:0] trigger;
   } seq_type;

   typedef struct packed {
      seq_type             seq;
      logic [SAMPLE_W-1:0] sample;
   } stage_type;

   function automatic logic [READING_W-1:0] water_convert(input logic [SAMPLE_W-1:0] s);
      logic [18:0]        offset;
      logic [8:0]         slope;
      logic [20:0]        prod;
      logic signed [21:0] diff;
      if (s < WATER_BREAK_0) begin
         offset = WATER_OFFSET_0;
         slope = WATER_SLOPE_0;
      end else if (s < WATER_BREAK_1) begin
         offset = WATER_OFFSET_1;
         slope = WATER_SLOPE_1;
      end else if (s < WATER_BREAK_2) begin
         offset = WATER_OFFSET_2;
         slope = WATER_SLOPE_2;
      end else if (s < WATER_BREAK_3) begin
         offset = WATER_OFFSET_3;
         slope = WATER_SLOPE_3;
      end else begin
         offset = WATER_OFFSET_4;
         slope = WATER_SLOPE_4;
      end
      prod = 21'(s) * 21'(slope);
      diff = $signed({3'b000, offset}) - $signed({1'b0, prod});
      return diff[READING_W-1:0];
   endfunction

endpackage

// ===== src/engine_sensor_sample_qualifier_unit.sv =====
// channel  ports                                    moves
// req      req_valid, req_ready, req_data           converter, sample, running
// rsp      rsp_valid, rsp_ready, rsp_data           sensor, reading, fault, next, trigger
// csr      csr_write_en, csr_index, csr_wdata       one register write per cycle
//
// one transfer per cycle in each direction unless rsp stalls; req goes to rsp through
// the input register, then window check and water conversion into the result register
// shared converter channel advances at each req transfer with converter set
// synchronous reset: channel back to air temp, windows open to full scale, fallbacks 0
// a stalled rsp holds both stages; req_ready drops only when both are full and stalled
module engine_sensor_sample_qualifier_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  esq_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output esq_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_en,
   input  logic [esq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [esq_pkg::WINDOW_W-1:0]    csr_wdata
);
   import esq_pkg::*;

   cfg_type   cfg;
   seq_type   seq;
   rsp_type   rsp_next;
   logic      req_accept;
   logic      stage_move;
   logic      out_free;

   logic      stage_valid_ff;
   logic      stage_valid_in;
   stage_type stage_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_ff;

   esq_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   esq_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_data),
      .seq    (seq)
   );

   esq_qual u_qual (
      .stage (stage_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      stage_move = stage_valid_ff && out_free;
      req_ready = !stage_valid_ff || out_free;
      req_accept = req_valid && req_ready;
      stage_valid_in = req_accept || (stage_valid_ff && !stage_move);
      rsp_valid_in = stage_move || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff.seq <= seq;
         stage_ff.sample <= req_data.sample;
      end
      if (stage_move) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   a_ready_low_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_valid_ff && rsp_valid_ff)
      else $error("req stalled with a free stage");

   a_stage_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_move |=> stage_valid_ff && $stable(stage_ff))
      else $error("held stage lost its item");

   a_fault_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.fault == FAULT_NONE || rsp_ff.fault == FAULT_HIGH ||
                       rsp_ff.fault == FAULT_LOW)
      else $error("unused fault code on rsp");
`endif

endmodule

// ===== src/esq_csr.sv =====
module esq_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [esq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [esq_pkg::WINDOW_W-1:0]     csr_wdata,
   output esq_pkg::cfg_type                 cfg
);
   import esq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_AIR_FLOW_WINDOW:     cfg_in.window[0] = csr_wdata;
            REG_AIR_TEMP_WINDOW:     cfg_in.window[1] = csr_wdata;
            REG_WATER_TEMP_WINDOW:   cfg_in.window[2] = csr_wdata;
            REG_THROTTLE_WINDOW:     cfg_in.window[3] = csr_wdata;
            REG_AIR_FLOW_FALLBACK:
               cfg_in.fallback[0] = {6'd0, csr_wdata[SHORT_FALLBACK_W-1:0]};
            REG_AIR_TEMP_FALLBACK:
               cfg_in.fallback[1] = {6'd0, csr_wdata[SHORT_FALLBACK_W-1:0]};
            REG_WATER_TEMP_FALLBACK:
               cfg_in.fallback[2] = csr_wdata[FALLBACK_W-1:0];
            REG_THROTTLE_FALLBACK:
               cfg_in.fallback[3] = {6'd0, csr_wdata[SHORT_FALLBACK_W-1:0]};
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            cfg_ff.window[i] <= WINDOW_RESET;
            cfg_ff.fallback[i] <= '0;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/esq_seq.sv =====
module esq_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  esq_pkg::req_type req,
   output esq_pkg::seq_type seq
);
   import esq_pkg::*;

   logic [1:0] shared_ff;
   logic [1:0] shared_in;
   seq_type    shared_seq;

   always_comb begin
      unique case (shared_ff)
         SENSOR_WATER_TEMP: begin
            shared_seq.sensor = SENSOR_WATER_TEMP;
            shared_seq.next_channel = SENSOR_THROTTLE;
            shared_seq.trigger = req.running ? TRIGGER_CONV1 : TRIGGER_NONE;
         end
         SENSOR_THROTTLE: begin
            shared_seq.sensor = SENSOR_THROTTLE;
            shared_seq.next_channel = SENSOR_AIR_TEMP;
            shared_seq.trigger = req.running ? TRIGGER_CONV0 : TRIGGER_NONE;
         end
         default: begin
            // stray channel code runs as air temperature
            shared_seq.sensor = SENSOR_AIR_TEMP;
            shared_seq.next_channel = SENSOR_WATER_TEMP;
            shared_seq.trigger = req.running ? TRIGGER_CONV1 : TRIGGER_NONE;
         end
      endcase
   end

   always_comb begin
      if (req.converter) begin
         seq = shared_seq;
      end else begin
         seq.sensor = SENSOR_AIR_FLOW;
         seq.next_channel = SENSOR_AIR_FLOW;
         seq.trigger = req.running ? TRIGGER_CONV1 : TRIGGER_NONE;
      end
      shared_in = (accept && req.converter) ? shared_seq.next_channel : shared_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_ff <= SENSOR_AIR_TEMP;
      end else begin
         shared_ff <= shared_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_shared_never_air_flow: assert property (@(posedge clock) disable iff (reset)
      shared_ff != SENSOR_AIR_FLOW)
      else $error("shared channel holds air flow");

   a_air_flow_keeps_shared: assert property (@(posedge clock) disable iff (reset)
      accept && !req.converter |=> $stable(shared_ff))
      else $error("air flow transfer moved shared channel");
`endif

endmodule

// ===== src/esq_qual.sv =====
module esq_qual (
   input  esq_pkg::stage_type stage,
   input  esq_pkg::cfg_type   cfg,
   output esq_pkg::rsp_type   rsp
);
   import esq_pkg::*;

   logic [WINDOW_W-1:0]   window;
   logic [FALLBACK_W-1:0] fallback;
   logic [SAMPLE_W-1:0]   win_min;
   logic [SAMPLE_W-1:0]   win_max;
   logic [READING_W-1:0]  pass_value;

   always_comb begin
      window = cfg.window[stage.seq.sensor];
      fallback = cfg.fallback[stage.seq.sensor];
      win_min = window[SAMPLE_W-1:0];
      win_max = window[WINDOW_W-1:SAMPLE_W];

      if (stage.seq.sensor == SENSOR_WATER_TEMP) begin
         pass_value = water_convert(stage.sample);
      end else begin
         pass_value = {8'd0, stage.sample};
      end

      rsp.sensor = stage.seq.sensor;
      rsp.next_channel = stage.seq.next_channel;
      rsp.trigger = stage.seq.trigger;
      // maximum is checked first
      if (stage.sample > win_max) begin
         rsp.fault = FAULT_HIGH;
         rsp.reading = $signed({2'b00, fallback});
      end else if (stage.sample < win_min) begin
         rsp.fault = FAULT_LOW;
         rsp.reading = $signed({2'b00, fallback});
      end else begin
         rsp.fault = FAULT_NONE;
         rsp.reading = $signed(pass_value);
      end
   end

endmodule
